// ----- rtl/iprl_pkg.sv -----
// Package: shared types and constants for the IPv4 route lookup block
`timescale 1ns / 1ps
`default_nettype none
package iprl_pkg;

    localparam int ROUTE_ENTRIES = 64;
    localparam int IDX_W = $clog2(ROUTE_ENTRIES);
    localparam int CNT_W = $clog2(ROUTE_ENTRIES + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_WORD   = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        V_FORWARD = 3'd0,
        V_LOCAL   = 3'd1,
        V_EXPIRED = 3'd2,
        V_NOROUTE = 3'd3,
        V_ADDED   = 3'd4,
        V_FULL    = 3'd5
    } t_verdict;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] route_dest;
        logic [5:0]  route_mask_len;
        logic [31:0] route_next_hop;
        logic [31:0] header_word;
        logic        last_word;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [31:0] next_hop;
        logic [7:0]  new_ttl;
        logic [15:0] new_checksum;
    } t_out_item;

    // Task handed from the front end to the back end through the queue
    typedef enum logic [1:0] {
        JOB_CLEAR  = 2'd0,
        JOB_ADD    = 2'd1,
        JOB_DECIDE = 2'd2
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [31:0] addr;      // route network or packet destination
        logic [5:0]  len;       // saturated prefix length
        logic [31:0] hop;
        logic [7:0]  ttl;
        logic [15:0] csum;      // final checksum (already inverted)
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_CMP  = 2'd2
    } t_bk_state;

    // Prefix mask from a length already saturated to 32
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] m;
        m = 32'hFFFF_FFFF;
        if (len == 6'd0) begin
            m = 32'd0;
        end else if (len < 6'd32) begin
            m = 32'hFFFF_FFFF << (6'd32 - len);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/iprl_front.sv -----
// Front end: header word folding, classification, job generation
`timescale 1ns / 1ps
`default_nettype none
module iprl_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire iprl_pkg::t_in_item i_item,
    output iprl_pkg::t_job       o_job,
    output logic                 o_job_valid
);

    logic [16:0] r_sum;
    logic [3:0]  r_pos;
    logic [7:0]  r_ttl;
    logic [31:0] r_dest;

    logic [15:0] hi, lo;
    logic [16:0] s1, s2;
    logic [7:0]  ttl_now;
    logic [31:0] dest_now;
    logic [16:0] t1;
    logic [15:0] t2;
    logic [5:0]  sat_len;

    // Word contribution with TTL decremented and checksum zeroed
    always_comb begin
        hi       = i_item.header_word[31:16];
        lo       = i_item.header_word[15:0];
        ttl_now  = r_ttl;
        dest_now = r_dest;
        if (r_pos == 4'd2) begin
            ttl_now = i_item.header_word[31:24];
            hi      = {ttl_now - 8'd1, i_item.header_word[23:16]};
            lo      = 16'd0;
        end else if (r_pos == 4'd4) begin
            dest_now = i_item.header_word;
        end
        s1 = {1'b0, r_sum[15:0]} + {16'd0, r_sum[16]} + {1'b0, hi};
        s1 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
        s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]} + {1'b0, lo};
        s2 = {1'b0, s2[15:0]} + {16'd0, s2[16]};
        t1 = {1'b0, s2[15:0]} + {16'd0, s2[16]};
        t2 = t1[15:0] + {15'd0, t1[16]};
        sat_len = (i_item.route_mask_len > 6'd32) ? 6'd32 : i_item.route_mask_len;
    end

    // Packet accumulation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_ttl  <= '0;
            r_dest <= '0;
        end else if (i_take && i_item.cmd == iprl_pkg::CMD_WORD) begin
            if (i_item.last_word) begin
                r_sum  <= '0;
                r_pos  <= '0;
                r_ttl  <= '0;
                r_dest <= '0;
            end else begin
                r_sum  <= s2;
                r_pos  <= (r_pos == 4'd15) ? r_pos : r_pos + 4'd1;
                r_ttl  <= ttl_now;
                r_dest <= dest_now;
            end
        end
    end

    // Job build
    always_comb begin
        o_job.kind  = iprl_pkg::JOB_CLEAR;
        o_job.addr  = dest_now;
        o_job.len   = sat_len;
        o_job.hop   = i_item.route_next_hop;
        o_job.ttl   = ttl_now;
        o_job.csum  = ~t2;
        o_job_valid = 1'b0;
        case (i_item.cmd)
            iprl_pkg::CMD_CLEAR: begin
                o_job_valid = i_take;
            end
            iprl_pkg::CMD_ADD: begin
                o_job.kind  = iprl_pkg::JOB_ADD;
                o_job.addr  = i_item.route_dest;
                o_job_valid = i_take;
            end
            iprl_pkg::CMD_WORD: begin
                o_job.kind  = iprl_pkg::JOB_DECIDE;
                o_job_valid = i_take && i_item.last_word;
            end
            default: o_job_valid = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/iprl_queue.sv -----
// Two-entry job queue between front and back ends
`timescale 1ns / 1ps
`default_nettype none
module iprl_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire iprl_pkg::t_job i_job,
    input  wire logic          i_pop,
    output iprl_pkg::t_job     o_job,
    output logic               o_valid,
    output logic               o_full
);

    iprl_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/iprl_back.sv -----
// Back end: route table memory, table updates and first-match scan
`timescale 1ns / 1ps
`default_nettype none
module iprl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [31:0]   i_local_address,
    input  wire iprl_pkg::t_job i_job,
    input  wire logic          i_job_valid,
    output logic               o_pop,
    output logic               o_idle,
    output logic               o_res_valid,
    output iprl_pkg::t_out_item o_res
);

    localparam int DATA_W = 32 + 6 + 32;

    logic [DATA_W-1:0] r_mem [iprl_pkg::ROUTE_ENTRIES];
    logic [DATA_W-1:0] r_rd;

    iprl_pkg::t_bk_state r_state, n_state;
    logic [iprl_pkg::CNT_W-1:0] r_count, n_count;
    logic [iprl_pkg::CNT_W-1:0] r_idx, n_idx;
    iprl_pkg::t_job r_job, n_job;
    logic r_res_valid, n_res_valid;
    iprl_pkg::t_out_item r_res, n_res;

    logic wr_en;
    logic rd_en;
    logic [iprl_pkg::IDX_W-1:0] rd_addr;
    logic [31:0] mask;
    logic hit;

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_idle      = (r_state == iprl_pkg::BK_IDLE);

    assign mask = iprl_pkg::prefix_mask(r_rd[37:32]);
    assign hit  = ((r_rd[69:38] & mask) == (r_job.addr & mask));

    // Route table memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[iprl_pkg::IDX_W-1:0]] <= {i_job.addr, i_job.len, i_job.hop};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iprl_pkg::BK_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
        r_idx <= n_idx;
        r_job <= n_job;
        r_res <= n_res;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_job       = r_job;
        n_res_valid = 1'b0;
        n_res       = '0;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_idx[iprl_pkg::IDX_W-1:0];
        case (r_state)
            iprl_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    case (i_job.kind)
                        iprl_pkg::JOB_CLEAR: n_count = '0;
                        iprl_pkg::JOB_ADD: begin
                            n_res_valid = 1'b1;
                            if (r_count == iprl_pkg::CNT_W'(iprl_pkg::ROUTE_ENTRIES)) begin
                                n_res.verdict = iprl_pkg::V_FULL;
                            end else begin
                                wr_en         = 1'b1;
                                n_count       = r_count + 1'b1;
                                n_res.verdict = iprl_pkg::V_ADDED;
                            end
                        end
                        iprl_pkg::JOB_DECIDE: begin
                            n_job = i_job;
                            if (i_job.ttl == 8'd0) begin
                                n_res_valid   = 1'b1;
                                n_res.verdict = iprl_pkg::V_EXPIRED;
                            end else if (i_job.addr == i_local_address) begin
                                n_res_valid   = 1'b1;
                                n_res.verdict = iprl_pkg::V_LOCAL;
                            end else if (r_count == '0) begin
                                n_res_valid   = 1'b1;
                                n_res.verdict = iprl_pkg::V_NOROUTE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = iprl_pkg::BK_CMP;
                            end
                        end
                        default: n_count = r_count;
                    endcase
                end
            end
            iprl_pkg::BK_CMP: begin
                if (hit) begin
                    n_res_valid        = 1'b1;
                    n_res.verdict      = iprl_pkg::V_FORWARD;
                    n_res.next_hop     = r_rd[31:0];
                    n_res.new_ttl      = r_job.ttl - 8'd1;
                    n_res.new_checksum = r_job.csum;
                    n_state            = iprl_pkg::BK_IDLE;
                end else if (r_idx + 1'b1 == r_count) begin
                    n_res_valid   = 1'b1;
                    n_res.verdict = iprl_pkg::V_NOROUTE;
                    n_state       = iprl_pkg::BK_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = n_idx[iprl_pkg::IDX_W-1:0];
                end
            end
            default: n_state = iprl_pkg::BK_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/ipv4_forward_route_lookup.sv -----
// Top level: IPv4 forwarding route lookup (front end, job queue, back end)
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------
//  command  | i_start / o_busy       | i_item  (iprl_pkg::t_in_item)
//  result   | o_valid (one cycle)    | o_item  (iprl_pkg::t_out_item)
//  config   | i_cfg_we               | i_cfg_wdata (local address)
//
// Header words and table commands are taken one per cycle while the job queue
// has room; a decision scans the route table one entry per cycle, while table
// adds and early verdicts are settled in the idle state without a scan. Reset is
// synchronous; no clearing pass is needed. The receiver cannot stall: each
// result is a single-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_forward_route_lookup (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire iprl_pkg::t_in_item i_item,
    output logic                   o_valid,
    output iprl_pkg::t_out_item    o_item,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_wdata
);

    logic [31:0] r_local;
    logic take;
    iprl_pkg::t_job f_job, q_job;
    logic f_valid, q_valid, q_full, q_pop, bk_idle;

    assign o_busy = q_full;
    assign take   = i_start && !o_busy;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local <= '0;
        end else if (i_cfg_we) begin
            r_local <= i_cfg_wdata;
        end
    end

    iprl_front u_front (
        .i_clk, .i_rst_n,
        .i_take      (take),
        .i_item      (i_item),
        .o_job       (f_job),
        .o_job_valid (f_valid)
    );

    iprl_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (f_valid),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    iprl_back u_back (
        .i_clk, .i_rst_n,
        .i_local_address (r_local),
        .i_job           (q_job),
        .i_job_valid     (q_valid),
        .o_pop           (q_pop),
        .o_idle          (bk_idle),
        .o_res_valid     (o_valid),
        .o_res           (o_item)
    );

`ifndef NO_ASSERTIONS
    // Queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !f_valid) else $error("job queue overflow");
    // Back end only pops when idle and a job is present
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (q_valid && bk_idle)) else $error("pop without job");
    // A forward verdict always carries a nonzero-origin TTL
    a_fwd_ttl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.verdict == iprl_pkg::V_FORWARD) |-> o_item.new_ttl != 8'hFF)
        else $error("forward with expired ttl");
`endif

endmodule
`default_nettype wire

// ----- test/ipv4_forward_route_lookup_tb.sv -----
// Testbench: IPv4 route lookup, directed and randomized commands checked against a local predictor
`timescale 1ns / 1ps
module ipv4_forward_route_lookup_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 100;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    iprl_pkg::t_in_item i_item = '0;
    logic o_valid;
    iprl_pkg::t_out_item o_item;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    ipv4_forward_route_lookup dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_valid(o_valid), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    // Stimulus and expectation stores
    iprl_pkg::t_in_item  pending_cmds[$];
    iprl_pkg::t_out_item expected_verdicts[$];
    logic [31:0] known_nets[$];
    int idle_pct = 0;
    bit hold_sender = 1'b0;
    bit took_cmd = 1'b0;
    int errors = 0;
    int cycles = 0;

    // Predictor state
    logic [31:0] p_local;
    logic [31:0] p_net[iprl_pkg::ROUTE_ENTRIES];
    logic [5:0]  p_len[iprl_pkg::ROUTE_ENTRIES];
    logic [31:0] p_hop[iprl_pkg::ROUTE_ENTRIES];
    int          p_count;
    logic [31:0] p_sum;
    int          p_pos;
    logic [7:0]  p_ttl;
    logic [31:0] p_dest;

    function automatic logic [31:0] fold16(input logic [31:0] a);
        return {16'd0, a[15:0]} + {16'd0, a[31:16]};
    endfunction

    function automatic logic [31:0] net_mask(input logic [5:0] len);
        if (len == 6'd0) return 32'd0;
        if (len >= 6'd32) return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    task automatic push_verdict(input iprl_pkg::t_verdict v, input logic [31:0] hop,
                                input logic [7:0] ttl, input logic [15:0] ck);
        iprl_pkg::t_out_item r;
        r.verdict = v;
        r.next_hop = hop;
        r.new_ttl = ttl;
        r.new_checksum = ck;
        expected_verdicts = {expected_verdicts, r};
    endtask

    // Work out the verdict (if any) for one accepted command
    task automatic predict_verdict(input iprl_pkg::t_in_item it);
        logic [15:0] hi, lo;
        logic [31:0] tot;
        logic [7:0] ttl;
        logic [31:0] dest;
        bit found;
        found = 1'b0;
        if (it.cmd == iprl_pkg::CMD_CLEAR) begin
            p_count = 0;
        end else if (it.cmd == iprl_pkg::CMD_ADD) begin
            if (p_count >= iprl_pkg::ROUTE_ENTRIES) begin
                push_verdict(iprl_pkg::V_FULL, '0, '0, '0);
            end else begin
                p_net[p_count] = it.route_dest;
                p_len[p_count] = (it.route_mask_len > 6'd32) ? 6'd32 : it.route_mask_len;
                p_hop[p_count] = it.route_next_hop;
                p_count++;
                push_verdict(iprl_pkg::V_ADDED, '0, '0, '0);
            end
        end else if (it.cmd == iprl_pkg::CMD_WORD) begin
            hi = it.header_word[31:16];
            lo = it.header_word[15:0];
            if (p_pos == 2) begin
                p_ttl = it.header_word[31:24];
                hi = {p_ttl - 8'd1, hi[7:0]};
                lo = 16'd0;
            end else if (p_pos == 4) begin
                p_dest = it.header_word;
            end
            p_sum = fold16(p_sum + hi);
            p_sum = fold16(p_sum + lo);
            if (p_pos < 15) p_pos++;
            if (it.last_word) begin
                ttl = p_ttl;
                dest = p_dest;
                tot = fold16(fold16(p_sum));
                p_sum = '0; p_pos = 0; p_ttl = '0; p_dest = '0;
                if (ttl == 8'd0) begin
                    push_verdict(iprl_pkg::V_EXPIRED, '0, '0, '0);
                end else if (dest == p_local) begin
                    push_verdict(iprl_pkg::V_LOCAL, '0, '0, '0);
                end else begin
                    for (int i = 0; i < p_count; i++) begin
                        if (!found && ((p_net[i] ^ dest) & net_mask(p_len[i])) == 0) begin
                            found = 1'b1;
                            push_verdict(iprl_pkg::V_FORWARD, p_hop[i], ttl - 8'd1,
                                         ~tot[15:0]);
                        end
                    end
                    if (!found) push_verdict(iprl_pkg::V_NOROUTE, '0, '0, '0);
                end
            end
        end
    endtask

    // Monitor: acceptance, prediction, result check, timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            if (!i_rst_n) begin
                p_local = '0; p_count = 0; p_sum = '0; p_pos = 0; p_ttl = '0; p_dest = '0;
            end else if (i_cfg_we) begin
                p_local = i_cfg_wdata;
            end
            took_cmd = i_rst_n && i_start && !o_busy;
            if (took_cmd) predict_verdict(i_item);
            if (i_rst_n && o_valid) begin
                if (expected_verdicts.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", o_item);
                end else begin
                    iprl_pkg::t_out_item e;
                    e = expected_verdicts.pop_front();
                    if (e.verdict !== o_item.verdict || e.next_hop !== o_item.next_hop ||
                        e.new_ttl !== o_item.new_ttl ||
                        e.new_checksum !== o_item.new_checksum) begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p got %p", e, o_item);
                    end
                end
            end
        end
    end

    // Driver: one transaction offered at a time, random gaps
    always @(negedge i_clk) begin
        if (!i_start || took_cmd) begin
            if (i_rst_n && !hold_sender && pending_cmds.size() > 0 &&
                $urandom_range(0, 99) >= idle_pct) begin
                i_item <= pending_cmds.pop_front();
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    function automatic iprl_pkg::t_in_item noise_fields();
        logic [159:0] raw;
        iprl_pkg::t_in_item it;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(iprl_pkg::t_in_item)-1:0];
        return it;
    endfunction

    task automatic queue_clear();
        iprl_pkg::t_in_item it;
        it = noise_fields();
        it.cmd = iprl_pkg::CMD_CLEAR;
        pending_cmds = {pending_cmds, it};
        known_nets.delete();
    endtask

    task automatic queue_route(input logic [31:0] net, input logic [5:0] len,
                               input logic [31:0] hop);
        iprl_pkg::t_in_item it;
        it = noise_fields();
        it.cmd = iprl_pkg::CMD_ADD;
        it.route_dest = net;
        it.route_mask_len = len;
        it.route_next_hop = hop;
        pending_cmds = {pending_cmds, it};
        known_nets = {known_nets, net};
    endtask

    task automatic queue_packet(input logic [7:0] ttl, input logic [31:0] dest, input int nw);
        iprl_pkg::t_in_item it;
        for (int w = 0; w < nw; w++) begin
            it = noise_fields();
            it.cmd = iprl_pkg::CMD_WORD;
            if (w == 2) it.header_word[31:24] = ttl;
            if (w == 4) it.header_word = dest;
            it.last_word = (w == nw - 1);
            pending_cmds = {pending_cmds, it};
        end
    endtask

    task automatic queue_random_route();
        queue_route($urandom, 6'($urandom_range(0, 63)), $urandom);
    endtask

    // Packet with random content and word count, aimed at known routes, local or anywhere
    task automatic queue_random_packet();
        logic [31:0] dest;
        logic [7:0] ttl;
        int r;
        r = $urandom_range(0, 99);
        dest = $urandom;
        if (r < 45 && known_nets.size() > 0)
            dest = known_nets[$urandom_range(0, known_nets.size() - 1)] ^
                   ($urandom >> $urandom_range(0, 31));
        else if (r < 60)
            dest = p_local;
        r = $urandom_range(0, 9);
        ttl = (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'd255 : 8'($urandom);
        queue_packet(ttl, dest, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 5);
    endtask

    task automatic wait_quiet();
        while (pending_cmds.size() > 0 || i_start || expected_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_local(input logic [31:0] addr);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= addr;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int pct, input logic [31:0] addr);
        iprl_pkg::t_in_item it;
        int n;
        bit filled;
        wait_quiet();
        write_local(addr);
        idle_pct = pct;
        n = 0;
        filled = 1'b0;
        while (n < 310) begin
            int r;
            r = $urandom_range(0, 99);
            if (!filled && n >= 100) begin
                // fill past capacity to hit the full table case
                for (int k = 0; k < 70; k++) queue_random_route();
                n += 70;
                filled = 1'b1;
            end else if (r < 3) begin
                queue_clear(); n++;
            end else if (r < 20) begin
                queue_random_route(); n++;
            end else if (r < 92) begin
                queue_random_packet(); n += 5;
            end else begin
                it = noise_fields();
                if (r < 96) it.cmd = iprl_pkg::CMD_UNUSED;
                pending_cmds = {pending_cmds, it}; n++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: saturation, first match, default route, TTL and length corners
        write_local(32'h0A00_0001);
        queue_clear();
        queue_route(32'hC0A8_0001, 6'd63, 32'h1111_1111);
        queue_route(32'hC0A8_0000, 6'd24, 32'h2222_2222);
        queue_route(32'hFFFF_FFFF, 6'd0, 32'hFFFF_FFFF);
        queue_packet(8'd64, 32'hC0A8_0001, 5);
        queue_packet(8'd255, 32'hC0A8_00FF, 5);
        queue_packet(8'd1, 32'h0102_0304, 5);
        queue_packet(8'd0, 32'hC0A8_0001, 5);
        queue_packet(8'd9, 32'h0A00_0001, 5);
        queue_packet(8'd9, 32'h0, 2);
        queue_packet(8'd200, 32'h0, 17);
        pending_cmds = {pending_cmds,
                        iprl_pkg::t_in_item'{cmd: iprl_pkg::CMD_UNUSED, route_dest: '1,
                                             route_mask_len: '1, route_next_hop: '1,
                                             header_word: '1, last_word: 1'b1}};
        queue_clear();
        queue_packet(8'd5, 32'h0A00_0002, 5);
        // pause the sender mid-stream until all results have come back
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b1;
        while (i_start || expected_verdicts.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        wait_quiet();

        run_phase(0, 32'h0000_0000);
        run_phase(79, 32'hFFFF_FFFF);
        run_phase(0, $urandom);
        run_phase(18, 32'h0A00_0001);
        wait_quiet();

        if (errors == 0 && expected_verdicts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ----- ipv4_forward_route_lookup.f -----
rtl/iprl_pkg.sv
rtl/iprl_front.sv
rtl/iprl_queue.sv
rtl/iprl_back.sv
rtl/ipv4_forward_route_lookup.sv
test/ipv4_forward_route_lookup_tb.sv
